@@ sv/ptw_pkg.sv @@
// Shared types, constants and a helper function of the page-table walker.
`default_nettype none

package ptw_pkg;

	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = 9;
	localparam int POOL_FRAMES_DEF   = 16;
	localparam int FCNT_W            = 5;
	localparam int PFN_W             = 40;
	localparam int ENTRY_W           = 64;
	localparam int CFG_W             = 40;
	localparam int CFG_IDX_W         = 1;

	localparam logic [PFN_W-1:0]  POOL_FIRST_RST  = 40'd4096;
	localparam logic [FCNT_W-1:0] POOL_FRAMES_RST = 5'd16;

	// Command codes; the unused code behaves as a lookup.
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_MAP    = 2'd1;
	localparam logic [1:0] CMD_DEMAND = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POOL_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_FRAMES = 1'b1;

	// Entry bit positions.
	localparam int B_PRESENT = 0;
	localparam int B_HUGE    = 7;

	// Low attribute bits of a new table entry and of a demand-fault leaf.
	localparam logic [11:0] TABLE_ATTR  = 12'h007;
	localparam logic [11:0] DEMAND_ATTR = 12'h027;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOENT = 2'd1,
		ST_NOMEM = 2'd2,
		ST_PROT  = 2'd3
	} ptw_status_t;

	// What the entry just read means for the walk.
	typedef enum logic [2:0] {
		WALK_STOP,
		WALK_DESCEND,
		WALK_CREATE,
		WALK_NOENT,
		WALK_NOMEM
	} ptw_walk_t;

	typedef enum logic [1:0] {
		VSEL_ZERO,
		VSEL_ENTRY,
		VSEL_LEAF
	} ptw_vsel_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_TAKE,
		S_DONE
	} ptw_state_t;

	typedef struct packed {
		logic        clr_wr;
		logic        load;
		logic        rd;
		logic        step;
		logic        take;
		logic        restart;
		logic        leaf_wr;
		logic        fin;
		ptw_status_t fin_st;
		ptw_vsel_t   vsel;
		logic        out_load;
	} ptw_cmd_t;

	typedef struct packed {
		logic       clr_last;
		ptw_walk_t  walk;
		logic       present;
		logic       alloc_ok;
		logic       out_busy;
		logic [1:0] cmd;
		logic       create;
	} ptw_stat_t;

	// Table index for a level, taken from address bits 47..12.
	function automatic logic [IDX_W-1:0] level_index(input logic [47:0] va,
			input logic [1:0] lvl);
		logic [IDX_W-1:0] ix;
		case (lvl)
			2'd0:    ix = va[47:39];
			2'd1:    ix = va[38:30];
			2'd2:    ix = va[29:21];
			default: ix = va[20:12];
		endcase
		return ix;
	endfunction

endpackage

`default_nettype wire

@@ sv/ptw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/ptw_ctrl.sv @@
// Controller state machine that sequences clearing, walks, allocation and results.
`default_nettype none

module ptw_ctrl
	import ptw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire ptw_stat_t stat,
	output ptw_cmd_t       cmd,
	output ptw_state_t     state
);

	ptw_state_t state_q, state_d;
	logic       is_lookup, is_demand;

	assign is_demand = (stat.cmd == CMD_DEMAND);
	assign is_lookup = (stat.cmd != CMD_MAP) && !is_demand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				unique case (stat.walk) inside
					WALK_CREATE, WALK_DESCEND: state_d = S_READ;
					WALK_STOP: begin
						if (!is_lookup && !stat.create && !stat.present) begin
							state_d = S_TAKE;
						end else begin
							state_d = S_DONE;
						end
					end
					WALK_NOENT: begin
						if (is_demand && !stat.create) begin
							state_d = S_TAKE;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_TAKE: begin
				if (stat.alloc_ok) begin
					state_d = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.fin_st = ST_OK;
		cmd.vsel   = VSEL_ZERO;
		unique case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE:  cmd.load = in_valid;
			S_READ:  cmd.rd = 1'b1;
			S_EVAL: begin
				unique case (stat.walk) inside
					WALK_CREATE, WALK_DESCEND: cmd.step = 1'b1;
					WALK_STOP: begin
						if (is_lookup) begin
							cmd.fin  = 1'b1;
							cmd.vsel = VSEL_ENTRY;
						end else if (stat.create) begin
							cmd.leaf_wr = 1'b1;
							cmd.fin     = 1'b1;
							cmd.vsel    = VSEL_LEAF;
						end else if (stat.present) begin
							cmd.fin    = 1'b1;
							cmd.fin_st = ST_PROT;
						end
					end
					WALK_NOENT: begin
						if (!(is_demand && !stat.create)) begin
							cmd.fin    = 1'b1;
							cmd.fin_st = ST_NOENT;
						end
					end
					default: begin
						cmd.fin    = 1'b1;
						cmd.fin_st = ST_NOMEM;
					end
				endcase
			end
			S_TAKE: begin
				if (stat.alloc_ok) begin
					cmd.take    = 1'b1;
					cmd.restart = 1'b1;
				end else begin
					cmd.fin    = 1'b1;
					cmd.fin_st = ST_NOMEM;
				end
			end
			S_DONE:  cmd.out_load = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign state    = state_q;

endmodule

`default_nettype wire

@@ sv/ptw_dp.sv @@
// Datapath: table memory, walk registers, frame allocator, configuration and result registers.
`default_nettype none

module ptw_dp
	import ptw_pkg::*;
#(
	parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [1:0]           cmd_in,
	input  wire logic [47:0]          virt_addr,
	input  wire logic [PFN_W-1:0]     phys_frame,
	input  wire logic [ENTRY_W-1:0]   flags,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [1:0]                status,
	output logic [ENTRY_W-1:0]        entry_value,
	output logic [1:0]                entry_level,
	output logic [FCNT_W-1:0]         frames_used,
	input  wire ptw_cmd_t             cmd,
	output ptw_stat_t                 stat
);

	localparam int FW    = $clog2(POOL_FRAMES);
	localparam int DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
	localparam int AW    = $clog2(DEPTH);

	// Configuration and control state.
	logic [PFN_W-1:0]  pool_first_q;
	logic [FCNT_W-1:0] pool_frames_q;
	logic [FCNT_W-1:0] next_free_q;
	logic [AW-1:0]     clr_q;
	logic [1:0]        lvl_q;
	logic              out_valid_q;

	// Item payload and walk registers.
	logic [1:0]         cmd_q;
	logic [47:0]        va_q;
	logic [PFN_W-1:0]   pf_q;
	logic [ENTRY_W-1:0] fl_q;
	logic               create_q;
	logic [FW-1:0]      cur_q;
	logic [FCNT_W-1:0]  df_q;
	ptw_status_t        res_st_q;
	logic [ENTRY_W-1:0] res_val_q;
	logic [1:0]         status_q;
	logic [ENTRY_W-1:0] entry_value_q;
	logic [1:0]         entry_level_q;
	logic [FCNT_W-1:0]  frames_used_q;

	logic [AW-1:0]      pos;
	logic [ENTRY_W-1:0] rdata;
	logic [PFN_W-1:0]   ent_pfn;
	logic [PFN_W-1:0]   frame_off;
	logic               dangling;
	logic               alloc_ok;
	logic [FCNT_W-1:0]  fidx;
	logic [PFN_W-1:0]   frame_pfn;
	logic [ENTRY_W-1:0] table_ent;
	logic [ENTRY_W-1:0] leaf_val;
	ptw_walk_t          walk;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	assign pos = {cur_q, level_index(va_q, lvl_q)};

	ptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.rd),
		.raddr (pos),
		.rdata (rdata)
	);

	// Entry address as a pool frame index, modulo 2^40.
	assign ent_pfn   = rdata[51:12];
	assign frame_off = ent_pfn - pool_first_q;
	assign dangling  = (frame_off >= PFN_W'(next_free_q));
	assign alloc_ok  = (next_free_q < pool_frames_q) && (32'(next_free_q) < POOL_FRAMES);

	assign fidx      = cmd.leaf_wr ? df_q : next_free_q;
	assign frame_pfn = pool_first_q + PFN_W'(fidx);
	assign table_ent = {12'd0, frame_pfn, TABLE_ATTR};

	always_comb begin
		if (cmd_q == CMD_DEMAND) begin
			leaf_val = {1'b1, 11'd0, frame_pfn, DEMAND_ATTR};
		end else begin
			leaf_val = {12'd0, pf_q, 12'd0} | fl_q | ENTRY_W'(1);
		end
	end

	always_comb begin
		if (lvl_q == 2'd3 || rdata[B_HUGE]) begin
			walk = WALK_STOP;
		end else if (ent_pfn == '0) begin
			if (!create_q) begin
				walk = WALK_NOENT;
			end else if (alloc_ok) begin
				walk = WALK_CREATE;
			end else begin
				walk = WALK_NOMEM;
			end
		end else if (dangling) begin
			walk = WALK_NOENT;
		end else begin
			walk = WALK_DESCEND;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos;
		mem_wdata = leaf_val;
		if (cmd.clr_wr) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (cmd.step && walk == WALK_CREATE) begin
			mem_we    = 1'b1;
			mem_wdata = table_ent;
		end else if (cmd.leaf_wr) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_first_q  <= POOL_FIRST_RST;
			pool_frames_q <= POOL_FRAMES_RST;
			next_free_q   <= FCNT_W'(1);
			clr_q         <= '0;
			lvl_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POOL_FIRST) begin
					pool_first_q <= cfg_data[PFN_W-1:0];
				end else begin
					pool_frames_q <= cfg_data[FCNT_W-1:0];
				end
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if ((cmd.step && walk == WALK_CREATE) || cmd.take) begin
				next_free_q <= next_free_q + FCNT_W'(1);
			end
			if (cmd.load || cmd.restart) begin
				lvl_q <= '0;
			end else if (cmd.step) begin
				lvl_q <= lvl_q + 2'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= cmd_in;
			va_q     <= virt_addr;
			pf_q     <= phys_frame;
			fl_q     <= flags;
			create_q <= (cmd_in == CMD_MAP);
			cur_q    <= '0;
		end else if (cmd.restart) begin
			create_q <= 1'b1;
			cur_q    <= '0;
		end else if (cmd.step) begin
			if (walk == WALK_CREATE) begin
				cur_q <= FW'(next_free_q);
			end else begin
				cur_q <= frame_off[FW-1:0];
			end
		end
		if (cmd.take) begin
			df_q <= next_free_q;
		end
		if (cmd.fin) begin
			res_st_q <= cmd.fin_st;
			case (cmd.vsel)
				VSEL_ENTRY: res_val_q <= rdata;
				VSEL_LEAF:  res_val_q <= leaf_val;
				default:    res_val_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			status_q      <= res_st_q;
			entry_value_q <= res_val_q;
			entry_level_q <= lvl_q;
			frames_used_q <= next_free_q;
		end
	end

	assign stat.clr_last = (clr_q == AW'(DEPTH - 1));
	assign stat.walk     = walk;
	assign stat.present  = rdata[B_PRESENT];
	assign stat.alloc_ok = alloc_ok;
	assign stat.out_busy = out_valid_q && out_stall;
	assign stat.cmd      = cmd_q;
	assign stat.create   = create_q;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign entry_level = entry_level_q;
	assign frames_used = frames_used_q;

endmodule

`default_nettype wire

@@ sv/page_table_walk_demand_alloc.sv @@
// Each command is loaded, then every table level on its path is read and then judged, and
// the outcome is registered onto the result channel.
// A demand fault walks twice with a frame allocation between.
// One command at a time: a new one is accepted only once the last result has been loaded
// for output, so a stalled result holds it; the single table memory port and its registered read set the pace.
// Reset is asynchronous; afterwards a clearing pass zeroes all POOL_FRAMES*512 entries of
// the table memory (8192 by default), one entry a cycle, and no command is accepted meanwhile.
`default_nettype none

module page_table_walk_demand_alloc
	import ptw_pkg::*;
#(
	parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// Command channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [47:0]          virt_addr,
	input  wire logic [PFN_W-1:0]     phys_frame,
	input  wire logic [ENTRY_W-1:0]   flags,
	// Result channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [ENTRY_W-1:0]        entry_value,
	output logic [1:0]                entry_level,
	output logic [FCNT_W-1:0]         frames_used
);

	// The controller issues one command word per cycle and reads back the outcome of the
	// entry just fetched; all storage, address arithmetic and allocation lives in the
	// datapath.
	ptw_cmd_t   dp_cmd;
	ptw_stat_t  dp_stat;
	ptw_state_t state;

	ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd),
		.state    (state)
	);

	// The datapath owns the table memory. Each level is read, and judged in the next cycle,
	// where a missing table may also be allocated and its pointer written.
	ptw_dp #(
		.POOL_FRAMES (POOL_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_in      (cmd),
		.virt_addr   (virt_addr),
		.phys_frame  (phys_frame),
		.flags       (flags),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.entry_value (entry_value),
		.entry_level (entry_level),
		.frames_used (frames_used),
		.cmd         (dp_cmd),
		.stat        (dp_stat)
	);

`ifndef SYNTHESIS
	// A failed command never reports an entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (entry_value == '0))
		else $error("failed result carries a non-zero entry");

	// Leaf entries are written only where the walk has ended.
	a_leaf_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.leaf_wr |-> (dp_stat.walk == WALK_STOP))
		else $error("leaf write before the walk ended");

	// A data frame is taken only while the pool has room.
	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.take |-> dp_stat.alloc_ok)
		else $error("data frame taken from an exhausted pool");

	// No command transfer while the table memory is still being cleared.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_CLEAR) |-> (in_stall && !dp_cmd.load))
		else $error("command accepted during the clearing pass");
`endif

endmodule

`default_nettype wire
